// ===== rtl/core/sps_pkg.sv =====
// Shared types and codes for the sleep period scheduler.
// Used by the channel interfaces, the step logic and the top level.
package sps_pkg;

  localparam int unsigned CountW  = 24;
  localparam int unsigned PeriodW = 32;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned ActW    = 2;

  // Event codes carried in the action field.
  localparam logic [ActW-1:0] ACT_START = 2'd0;
  localparam logic [ActW-1:0] ACT_TIMER = 2'd1;
  localparam logic [ActW-1:0] ACT_GPIO  = 2'd2;

  // Deep power mode has no sleep timer.
  localparam logic [ModeW-1:0]   MODE_DEEP   = 2'd3;
  localparam logic [PeriodW-1:0] DEEP_REPORT = 32'd65000;

  typedef struct packed {
    logic [ActW-1:0]    action;
    logic [CountW-1:0]  counter_now;
    logic [PeriodW-1:0] sleep_periods;
    logic [ModeW-1:0]   power_mode;
    logic               gpio_wake_enable;
  } sps_item_t;

  typedef struct packed {
    logic [CountW-1:0]  compare_value;
    logic               load_compare;
    logic               timer_irq_enable;
    logic               enter_sleep;
    logic [ModeW-1:0]   sleep_mode;
    logic               done_res;
    logic [PeriodW-1:0] total_slept;
  } sps_result_t;

  typedef struct packed {
    logic [PeriodW-1:0] remaining;
    logic [PeriodW-1:0] accumulated;
    logic [CountW-1:0]  base_count;
    logic [ModeW-1:0]   active_mode;
    logic               gpio_armed;
    logic               busy;
  } sps_state_t;

endpackage

// ===== rtl/core/sps_if.sv =====
// Valid/ready channel interfaces for the sleep period scheduler.
// Depends on sps_pkg for the payload types.
interface sps_in_if;
  logic                valid;
  logic                ready;
  sps_pkg::sps_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sps_out_if;
  logic                 valid;
  logic                 ready;
  sps_pkg::sps_result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/sps_step.sv =====
// Combinational step logic: one event against the scheduler state.
// Depends on sps_pkg; registered on both sides by the top level.
module sps_step #(
  parameter int unsigned PeriodMax = 4000,
  parameter int unsigned TickShift = 12
) (
  input  sps_pkg::sps_item_t   item_i,
  input  sps_pkg::sps_state_t  state_i,
  output sps_pkg::sps_state_t  state_o,
  output sps_pkg::sps_result_t result_o
);

  localparam int unsigned SliceW = $clog2(PeriodMax + 1);
  localparam logic [sps_pkg::PeriodW-1:0] PeriodMaxW = sps_pkg::PeriodW'(PeriodMax);
  localparam logic [SliceW-1:0] PeriodMaxS = SliceW'(PeriodMax);

  function automatic logic [sps_pkg::CountW-1:0] next_cmp(
    input logic [sps_pkg::CountW-1:0]  now,
    input logic [sps_pkg::PeriodW-1:0] left
  );
    logic [SliceW-1:0] slice;
    slice = (left > PeriodMaxW) ? PeriodMaxS : left[SliceW-1:0];
    return now + (sps_pkg::CountW'(slice) << TickShift);
  endfunction

  function automatic logic [sps_pkg::PeriodW-1:0] sat_add(
    input logic [sps_pkg::PeriodW-1:0] a,
    input logic [sps_pkg::PeriodW-1:0] b
  );
    logic [sps_pkg::PeriodW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[sps_pkg::PeriodW] ? '1 : s[sps_pkg::PeriodW-1:0];
  endfunction

  logic [sps_pkg::CountW-1:0]  diff;
  logic [sps_pkg::PeriodW-1:0] elapsed;
  logic [sps_pkg::PeriodW-1:0] rem_less;

  // Elapsed counter periods since the last base, counted as at least one.
  assign diff     = item_i.counter_now - state_i.base_count;
  assign rem_less = state_i.remaining - PeriodMaxW;

  always_comb begin
    elapsed = sps_pkg::PeriodW'(diff >> TickShift);
    if (elapsed == '0) begin
      elapsed = sps_pkg::PeriodW'(1);
    end
  end

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    result_o.timer_irq_enable = state_i.busy && (state_i.active_mode != sps_pkg::MODE_DEEP);

    case (item_i.action)
      sps_pkg::ACT_START: begin
        state_o.accumulated = '0;
        state_o.remaining   = item_i.sleep_periods;
        state_o.active_mode = item_i.power_mode;
        result_o.timer_irq_enable = 1'b0;
        if (item_i.power_mode == sps_pkg::MODE_DEEP) begin
          state_o.gpio_armed   = 1'b1;
          state_o.remaining    = sps_pkg::PeriodW'(1);
          state_o.busy         = 1'b1;
          result_o.enter_sleep = 1'b1;
          result_o.sleep_mode  = item_i.power_mode;
        end else if (item_i.sleep_periods == '0) begin
          state_o.gpio_armed = item_i.gpio_wake_enable;
          state_o.busy       = 1'b0;
          result_o.done_res  = 1'b1;
        end else begin
          state_o.gpio_armed        = item_i.gpio_wake_enable;
          state_o.base_count        = item_i.counter_now;
          state_o.busy              = 1'b1;
          result_o.compare_value    = next_cmp(item_i.counter_now, item_i.sleep_periods);
          result_o.load_compare     = 1'b1;
          result_o.timer_irq_enable = 1'b1;
          result_o.enter_sleep      = 1'b1;
          result_o.sleep_mode       = item_i.power_mode;
        end
      end
      sps_pkg::ACT_TIMER, sps_pkg::ACT_GPIO: begin
        if (state_i.busy) begin
          if (state_i.active_mode == sps_pkg::MODE_DEEP) begin
            state_o.remaining = '0;
            state_o.busy      = 1'b0;
            result_o.timer_irq_enable = 1'b0;
            result_o.done_res    = 1'b1;
            result_o.total_slept = sps_pkg::DEEP_REPORT;
          end else if (item_i.action == sps_pkg::ACT_TIMER) begin
            if (state_i.remaining <= PeriodMaxW) begin
              state_o.accumulated = sat_add(state_i.accumulated, state_i.remaining);
              state_o.remaining   = '0;
              state_o.busy        = 1'b0;
              result_o.timer_irq_enable = 1'b0;
              result_o.done_res    = 1'b1;
              result_o.total_slept = state_o.accumulated;
            end else begin
              // Advance one full slice and reload the compare.
              state_o.base_count  = item_i.counter_now;
              state_o.accumulated = sat_add(state_i.accumulated, PeriodMaxW);
              state_o.remaining   = rem_less;
              result_o.compare_value    = next_cmp(item_i.counter_now, rem_less);
              result_o.load_compare     = 1'b1;
              result_o.timer_irq_enable = 1'b1;
              result_o.enter_sleep      = 1'b1;
              result_o.sleep_mode       = state_i.active_mode;
            end
          end else if (state_i.gpio_armed) begin
            state_o.accumulated = sat_add(state_i.accumulated, elapsed);
            state_o.remaining   = '0;
            state_o.busy        = 1'b0;
            result_o.timer_irq_enable = 1'b0;
            result_o.done_res    = 1'b1;
            result_o.total_slept = state_o.accumulated;
          end else begin
            // Unarmed wake: go back to sleep on the same compare.
            result_o.timer_irq_enable = 1'b1;
            result_o.enter_sleep      = 1'b1;
            result_o.sleep_mode       = state_i.active_mode;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/core/sleep_period_scheduler.sv =====
// Top level of the sleep period scheduler: input register, step logic, result register.
// Depends on sps_pkg, sps_if (sps_in_if, sps_out_if) and sps_step.
//
//   channel | dir | payload      | transfer when
//   --------+-----+--------------+--------------------------
//   in_i    | in  | sps_item_t   | in_i.valid && in_i.ready
//   out_o   | out | sps_result_t | out_o.valid && out_o.ready
//
// One result per event. The event is captured in the input register, then the
// step logic computes the result and the new state into the result register.
// Throughput is one event per cycle while the result register is free or drains.
// Reset clears both valid flags and all scheduler state (idle).
// A held result stalls the input register only when it is full; otherwise a
// new event is still taken while the result waits.
module sleep_period_scheduler #(
  parameter int unsigned PeriodMax = 4000,
  parameter int unsigned TickShift = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sps_in_if.sink      in_i,
  sps_out_if.source   out_o
);

  // Input register stage.
  logic               s1_valid_q;
  sps_pkg::sps_item_t s1_item_q;

  // Result register stage.
  logic                 out_valid_q;
  sps_pkg::sps_result_t out_data_q;

  // Scheduler state, updated when an event moves into the result register.
  sps_pkg::sps_state_t  state_q;
  sps_pkg::sps_state_t  state_d;
  sps_pkg::sps_result_t result_d;

  logic advance;

  // Move the captured event on whenever the result register is free or drains.
  assign advance    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  sps_step #(
    .PeriodMax (PeriodMax),
    .TickShift (TickShift)
  ) u_step (
    .item_i   (s1_item_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  // Capture the event payload on each input transfer.
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_item_q <= in_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the result until its transfer.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= result_d;
    end
  end

  // A finished sleep never asks for sleep or leaves the timer interrupt on.
  a_done_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.done_res |-> !out_data_q.enter_sleep &&
      !out_data_q.timer_irq_enable && !out_data_q.load_compare)
    else $error("finish result asks for sleep or timer");

  // A compare load always comes with a timed sleep request.
  a_load_sleeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.load_compare |-> out_data_q.enter_sleep &&
      out_data_q.timer_irq_enable && (out_data_q.sleep_mode != sps_pkg::MODE_DEEP))
    else $error("compare load without timed sleep");

  // A finish result leaves the scheduler idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && result_d.done_res |=> !state_q.busy)
    else $error("scheduler still busy after finish");

  // The state holds while no event moves into the result register.
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("state changed without an event");

endmodule

// ===== dv/sps_outcome_checker.sv =====
// Watches both channels of the sleep period scheduler, predicts every result
// and compares it field by field. Depends on sps_pkg and sps_if.
module sps_outcome_checker #(
  parameter int unsigned PeriodMax = 4000,
  parameter int unsigned TickShift = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sps_in_if           ev_mon,
  sps_out_if          res_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o,
  output int unsigned finished_o,
  output int unsigned deep_wakes_o,
  output int unsigned reloads_o
);
  timeunit 1ns;
  timeprecision 1ps;

  sps_pkg::sps_state_t  sched;
  sps_pkg::sps_result_t sleep_outcome_q[$];
  int unsigned fail_count = 0;
  int unsigned pending    = 0;
  int unsigned checked    = 0;
  int unsigned finished   = 0;
  int unsigned deep_wakes = 0;
  int unsigned reloads    = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;
  assign checked_o    = checked;
  assign finished_o   = finished;
  assign deep_wakes_o = deep_wakes;
  assign reloads_o    = reloads;

  function automatic logic [sps_pkg::PeriodW-1:0] sat_sum(
    input logic [sps_pkg::PeriodW-1:0] a,
    input logic [sps_pkg::PeriodW-1:0] b
  );
    logic [sps_pkg::PeriodW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[sps_pkg::PeriodW] ? '1 : s[sps_pkg::PeriodW-1:0];
  endfunction

  // Compare for the next slice: now + min(left, PeriodMax) periods, mod 2^24.
  function automatic logic [sps_pkg::CountW-1:0] slice_compare(
    input logic [sps_pkg::CountW-1:0]  now,
    input logic [sps_pkg::PeriodW-1:0] left
  );
    logic [sps_pkg::PeriodW-1:0] slice;
    logic [sps_pkg::PeriodW-1:0] ticks;
    slice = (left > PeriodMax) ? sps_pkg::PeriodW'(PeriodMax) : left;
    ticks = slice << TickShift;
    return now + ticks[sps_pkg::CountW-1:0];
  endfunction

  // Advance the scheduler state by one event and return its result.
  function automatic sps_pkg::sps_result_t schedule_event(input sps_pkg::sps_item_t ev);
    sps_pkg::sps_result_t        r;
    logic [sps_pkg::CountW-1:0]  span;
    logic [sps_pkg::PeriodW-1:0] elapsed;
    r = '0;
    r.timer_irq_enable = sched.busy && (sched.active_mode != sps_pkg::MODE_DEEP);
    if (ev.action == sps_pkg::ACT_START) begin
      sched.accumulated = '0;
      sched.remaining   = ev.sleep_periods;
      sched.active_mode = ev.power_mode;
      r.timer_irq_enable = 1'b0;
      if (ev.power_mode == sps_pkg::MODE_DEEP) begin
        sched.gpio_armed = 1'b1;
        sched.remaining  = 1;
        sched.busy       = 1'b1;
        r.enter_sleep    = 1'b1;
        r.sleep_mode     = ev.power_mode;
      end else if (ev.sleep_periods == '0) begin
        sched.gpio_armed = ev.gpio_wake_enable;
        sched.busy       = 1'b0;
        r.done_res       = 1'b1;
      end else begin
        sched.gpio_armed   = ev.gpio_wake_enable;
        sched.base_count   = ev.counter_now;
        r.compare_value    = slice_compare(ev.counter_now, ev.sleep_periods);
        r.load_compare     = 1'b1;
        r.timer_irq_enable = 1'b1;
        r.enter_sleep      = 1'b1;
        r.sleep_mode       = ev.power_mode;
        sched.busy         = 1'b1;
      end
    end else if (sched.busy &&
                 (ev.action == sps_pkg::ACT_TIMER || ev.action == sps_pkg::ACT_GPIO)) begin
      if (sched.active_mode == sps_pkg::MODE_DEEP) begin
        sched.remaining    = '0;
        sched.busy         = 1'b0;
        r.timer_irq_enable = 1'b0;
        r.done_res         = 1'b1;
        r.total_slept      = sps_pkg::DEEP_REPORT;
        deep_wakes++;
      end else if (ev.action == sps_pkg::ACT_TIMER) begin
        if (sched.remaining <= PeriodMax) begin
          sched.accumulated  = sat_sum(sched.accumulated, sched.remaining);
          sched.remaining    = '0;
          sched.busy         = 1'b0;
          r.timer_irq_enable = 1'b0;
          r.done_res         = 1'b1;
          r.total_slept      = sched.accumulated;
        end else begin
          sched.base_count   = ev.counter_now;
          sched.accumulated  = sat_sum(sched.accumulated, sps_pkg::PeriodW'(PeriodMax));
          sched.remaining    = sched.remaining - sps_pkg::PeriodW'(PeriodMax);
          r.compare_value    = slice_compare(ev.counter_now, sched.remaining);
          r.load_compare     = 1'b1;
          r.timer_irq_enable = 1'b1;
          r.enter_sleep      = 1'b1;
          r.sleep_mode       = sched.active_mode;
          reloads++;
        end
      end else if (sched.gpio_armed) begin
        span    = ev.counter_now - sched.base_count;
        elapsed = sps_pkg::PeriodW'(span >> TickShift);
        if (elapsed == '0) elapsed = 1;
        sched.accumulated  = sat_sum(sched.accumulated, elapsed);
        sched.remaining    = '0;
        sched.busy         = 1'b0;
        r.timer_irq_enable = 1'b0;
        r.done_res         = 1'b1;
        r.total_slept      = sched.accumulated;
      end else begin
        r.timer_irq_enable = 1'b1;
        r.enter_sleep      = 1'b1;
        r.sleep_mode       = sched.active_mode;
      end
    end
    return r;
  endfunction

  function automatic bit field_mismatch(input string name,
                                        input logic [sps_pkg::PeriodW-1:0] want,
                                        input logic [sps_pkg::PeriodW-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    sps_pkg::sps_result_t want;
    sps_pkg::sps_result_t got;
    bit                   bad;
    if (!rst_ni) begin
      sched = '0;
      sleep_outcome_q.delete();
      pending = 0;
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        got = res_mon.data;
        checked++;
        if (sleep_outcome_q.size() == 0) begin
          $error("result transfer with no event outstanding");
          fail_count++;
        end else begin
          want = sleep_outcome_q.pop_front();
          bad  = 1'b0;
          bad |= field_mismatch("compare_value", want.compare_value, got.compare_value);
          bad |= field_mismatch("load_compare", want.load_compare, got.load_compare);
          bad |= field_mismatch("timer_irq_enable", want.timer_irq_enable,
                                got.timer_irq_enable);
          bad |= field_mismatch("enter_sleep", want.enter_sleep, got.enter_sleep);
          bad |= field_mismatch("sleep_mode", want.sleep_mode, got.sleep_mode);
          bad |= field_mismatch("done_res", want.done_res, got.done_res);
          bad |= field_mismatch("total_slept", want.total_slept, got.total_slept);
          if (bad) fail_count++;
          if (want.done_res) finished++;
        end
      end
      if (ev_mon.valid && ev_mon.ready) sleep_outcome_q.push_back(schedule_event(ev_mon.data));
      pending = sleep_outcome_q.size();
    end
  end

endmodule

// ===== dv/sleep_period_scheduler_tb.sv =====
// Top of the sleep period scheduler bench: clock, reset, event stimulus,
// result back-pressure and verdict. Depends on sps_pkg, sps_if and sps_outcome_checker.
module sleep_period_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PeriodMax = 4000;
  localparam int unsigned TickShift = 12;

  // Action code the block does not decode; it must leave the state alone.
  localparam logic [sps_pkg::ActW-1:0]  ACT_NONE = 2'd3;
  localparam logic [sps_pkg::ModeW-1:0] MODE_PM0 = 2'd0;
  localparam logic [sps_pkg::ModeW-1:0] MODE_PM1 = 2'd1;
  localparam logic [sps_pkg::ModeW-1:0] MODE_PM2 = 2'd2;

  localparam int unsigned RandomEvents  = 1200;
  localparam int unsigned HoldOffCycles = 500;
  localparam int unsigned HoldOffAfter  = 150;   // results seen before the long hold-off
  localparam int unsigned DrainCycles   = 10;
  localparam int unsigned WatchdogLimit = 4000;  // well above hold-off and longest gaps

  logic clk_i = 1'b0;
  logic rst_ni;

  sps_in_if  ev_ch ();
  sps_out_if res_ch ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned finished;
  int unsigned deep_wakes;
  int unsigned reloads;

  int unsigned                events_sent = 0;
  logic [sps_pkg::CountW-1:0] sleep_clock = '0;  // model of the free-running sleep counter

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sleep_period_scheduler #(
    .PeriodMax(PeriodMax),
    .TickShift(TickShift)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (ev_ch),
    .out_o (res_ch)
  );

  sps_outcome_checker #(
    .PeriodMax(PeriodMax),
    .TickShift(TickShift)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ev_mon      (ev_ch),
    .res_mon     (res_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked),
    .finished_o  (finished),
    .deep_wakes_o(deep_wakes),
    .reloads_o   (reloads)
  );

  function automatic sps_pkg::sps_item_t make_event(
    input logic [sps_pkg::ActW-1:0]    act,
    input logic [sps_pkg::CountW-1:0]  now,
    input logic [sps_pkg::PeriodW-1:0] periods,
    input logic [sps_pkg::ModeW-1:0]   mode,
    input logic                        wake_en
  );
    sps_pkg::sps_item_t ev;
    ev.action           = act;
    ev.counter_now      = now;
    ev.sleep_periods    = periods;
    ev.power_mode       = mode;
    ev.gpio_wake_enable = wake_en;
    return ev;
  endfunction

  // Mostly back-to-back, often a few cycles, now and then a long pause.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Sleep lengths: zero, one slice, around the slice limit, a few slices, or any
  // 32-bit value (those are cut short by a wake or a new start).
  function automatic logic [sps_pkg::PeriodW-1:0] pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8)  return '0;
    if (r < 50) return sps_pkg::PeriodW'($urandom_range(1, PeriodMax));
    if (r < 60) return sps_pkg::PeriodW'(PeriodMax + $urandom_range(0, 1));
    if (r < 85) return sps_pkg::PeriodW'($urandom_range(PeriodMax + 1, 8 * PeriodMax));
    return sps_pkg::PeriodW'($urandom);
  endfunction

  // Move the sleep counter on; small steps land the GPIO elapsed time near zero.
  task automatic tick_sleep_clock();
    if ($urandom_range(0, 4) == 0) sleep_clock += sps_pkg::CountW'($urandom_range(0, 4095));
    else sleep_clock += sps_pkg::CountW'($urandom);
  endtask

  // Offer one event and hold it until the transfer. Valid stays high into the
  // next event when there is no gap, so it is never dropped and raised in one step.
  task automatic send_event(input sps_pkg::sps_item_t ev);
    int unsigned gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      ev_ch.valid = 1'b0;
    end
    @(negedge clk_i);
    ev_ch.valid = 1'b1;
    ev_ch.data  = ev;
    do @(posedge clk_i); while (!ev_ch.ready);
    events_sent++;
  endtask

  task automatic send_noise();
    tick_sleep_clock();
    send_event(make_event(sps_pkg::ActW'($urandom_range(0, 3)), sleep_clock,
                          sps_pkg::PeriodW'($urandom), sps_pkg::ModeW'($urandom),
                          1'($urandom)));
  endtask

  // Hit the extremes and each corner of the scheduling rules once.
  task automatic directed_events();
    // events while idle change nothing
    send_event(make_event(sps_pkg::ACT_TIMER, '0, '0, MODE_PM0, 1'b0));
    send_event(make_event(sps_pkg::ACT_GPIO, '1, '1, sps_pkg::MODE_DEEP, 1'b1));
    send_event(make_event(ACT_NONE, 24'h5a5a5a, 32'ha5a5a5a5, MODE_PM2, 1'b1));
    // zero length finishes at once
    send_event(make_event(sps_pkg::ACT_START, 24'h123456, '0, MODE_PM0, 1'b1));
    // deep mode: timer-less, either wake reports the fixed total
    send_event(make_event(sps_pkg::ACT_START, 24'h000001, '1, sps_pkg::MODE_DEEP, 1'b0));
    send_event(make_event(ACT_NONE, 24'h000002, '0, MODE_PM0, 1'b0));
    send_event(make_event(sps_pkg::ACT_TIMER, 24'h000003, '0, MODE_PM0, 1'b0));
    send_event(make_event(sps_pkg::ACT_START, 24'h7fffff, '0, sps_pkg::MODE_DEEP, 1'b0));
    send_event(make_event(sps_pkg::ACT_GPIO, 24'h800000, '0, MODE_PM0, 1'b0));
    // single period, compare wraps past the top of the counter
    send_event(make_event(sps_pkg::ACT_START, '1, 32'd1, MODE_PM1, 1'b0));
    send_event(make_event(sps_pkg::ACT_TIMER, 24'h000fff, '0, MODE_PM0, 1'b0));
    // one over the slice limit: reload with GPIO armed, then finish
    send_event(make_event(sps_pkg::ACT_START, 24'hfff000,
                          sps_pkg::PeriodW'(PeriodMax + 1), MODE_PM2, 1'b1));
    send_event(make_event(ACT_NONE, 24'hfff100, '0, MODE_PM0, 1'b0));
    send_event(make_event(sps_pkg::ACT_TIMER, 24'h000123, '0, MODE_PM0, 1'b0));
    send_event(make_event(sps_pkg::ACT_TIMER, 24'h001123, '0, MODE_PM0, 1'b0));
    // unarmed GPIO resleeps; a new start drops the running sleep
    send_event(make_event(sps_pkg::ACT_START, '0, 32'd10000, MODE_PM0, 1'b0));
    send_event(make_event(sps_pkg::ACT_GPIO, 24'h400000, '0, MODE_PM0, 1'b0));
    send_event(make_event(sps_pkg::ACT_START, 24'h000005, '1, MODE_PM0, 1'b1));
    // GPIO wake with no counter progress still counts one period
    send_event(make_event(sps_pkg::ACT_GPIO, 24'h000005, '0, MODE_PM0, 1'b0));
    // exactly one full slice, GPIO wake just behind the base: elapsed wraps
    send_event(make_event(sps_pkg::ACT_START, 24'h000100,
                          sps_pkg::PeriodW'(PeriodMax), MODE_PM1, 1'b1));
    send_event(make_event(sps_pkg::ACT_GPIO, 24'h0000ff, '0, MODE_PM0, 1'b0));
    // two full slices through the timer
    send_event(make_event(sps_pkg::ACT_START, 24'h800000,
                          sps_pkg::PeriodW'(2 * PeriodMax), MODE_PM2, 1'b0));
    send_event(make_event(sps_pkg::ACT_TIMER, 24'h000000, '0, MODE_PM0, 1'b0));
    send_event(make_event(sps_pkg::ACT_TIMER, 24'h7a1200, '0, MODE_PM0, 1'b0));
  endtask

  // One well-formed sleep: a start, then expiries and wakes with random content,
  // sometimes a stray event or a fresh start that abandons it.
  task automatic random_sleep();
    logic [sps_pkg::PeriodW-1:0] len;
    logic [sps_pkg::ModeW-1:0]   mode;
    logic                        wake_en;
    logic [sps_pkg::ActW-1:0]    act;
    int unsigned                 slices;
    int unsigned                 r;
    mode    = ($urandom_range(0, 9) == 0) ? sps_pkg::MODE_DEEP
                                          : sps_pkg::ModeW'($urandom_range(0, 2));
    wake_en = 1'($urandom);
    len     = pick_length();
    if (len == '0 || mode == sps_pkg::MODE_DEEP) slices = 1;
    else if (len > 8 * PeriodMax) slices = $urandom_range(1, 8);
    else slices = (len + PeriodMax - 1) / PeriodMax;
    tick_sleep_clock();
    send_event(make_event(sps_pkg::ACT_START, sleep_clock, len, mode, wake_en));
    if (len == '0 && mode != sps_pkg::MODE_DEEP) return;
    for (int unsigned i = 0; i < slices; i++) begin
      r = $urandom_range(0, 99);
      if (r < 75) act = sps_pkg::ACT_TIMER;
      else if (r < 87) act = sps_pkg::ACT_GPIO;
      else if (r < 94) act = ACT_NONE;
      else begin
        send_noise();
        return;
      end
      tick_sleep_clock();
      send_event(make_event(act, sleep_clock, sps_pkg::PeriodW'($urandom),
                            sps_pkg::ModeW'($urandom), 1'($urandom)));
      // an armed GPIO wake or any wake in deep mode ends the sleep
      if (mode == sps_pkg::MODE_DEEP && act != ACT_NONE) return;
      if (act == sps_pkg::ACT_GPIO && wake_en) return;
    end
  endtask

  initial begin : stimulus
    int unsigned goal;
    ev_ch.valid = 1'b0;
    ev_ch.data  = '0;
    rst_ni      = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    directed_events();
    goal = events_sent + RandomEvents;
    while (events_sent < goal) begin
      if ($urandom_range(0, 99) < 85) random_sleep();
      else send_noise();
    end
    @(negedge clk_i);
    ev_ch.valid = 1'b0;

    // drain: the watchdog bounds this wait
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("Run covered %0d events and %0d results: %0d sleeps finished, %0d deep wakes,",
             events_sent, checked, finished, deep_wakes);
    $display("  %0d slice reloads, with one %0d-cycle result hold-off.", reloads,
             HoldOffCycles);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Result side: runs of steady ready, short and long stalls, and one long
  // hold-off while events keep coming so the block fills and stalls its input.
  initial begin : result_sink
    bit          held_off;
    int unsigned r;
    held_off     = 1'b0;
    res_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held_off && checked >= HoldOffAfter) begin
        held_off = 1'b1;
        repeat (HoldOffCycles) begin
          @(negedge clk_i);
          res_ch.ready = 1'b0;
        end
      end
      r = $urandom_range(0, 99);
      if (r < 25) begin
        repeat ($urandom_range(10, 50)) begin
          @(negedge clk_i);
          res_ch.ready = 1'b1;
        end
      end else begin
        repeat ((r < 88) ? $urandom_range(1, 3) : $urandom_range(10, 40)) begin
          @(negedge clk_i);
          res_ch.ready = 1'b0;
        end
        repeat ($urandom_range(1, 4)) begin
          @(negedge clk_i);
          res_ch.ready = 1'b1;
        end
      end
    end
  end

  // Count cycles with no transfer on either channel; give up at the limit.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((ev_ch.valid && ev_ch.ready) || (res_ch.valid && res_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no transfer for %0d cycles, %0d results outstanding", quiet, pending);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/sps_pkg.sv
rtl/core/sps_if.sv
rtl/core/sps_step.sv
rtl/core/sleep_period_scheduler.sv
dv/sps_outcome_checker.sv
dv/sleep_period_scheduler_tb.sv
